// ===== hdl/amsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package amsc_pkg;

    // field widths
    localparam int AXIS_W  = 16;
    localparam int ABS_W   = AXIS_W + 1;
    localparam int SUM_W   = 32;
    localparam int MAG_W   = 16;
    localparam int COUNT_W = 16;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // item function codes
    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_BUTTON = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // register index
    localparam logic [ADDR_W-3:0] REG_THRESHOLD = '0;

    // reset values: 8 m/s^2 and 10.5 m/s^2 at 16384 lsb per g, g = 9.81
    localparam logic [MAG_W-1:0]   THRESHOLD_RESET = 16'd13361;
    localparam logic [MAG_W-1:0]   LAST_MAG_RESET  = 16'd17537;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic                     button_level;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] step_count;
        logic               is_paused;
        logic [MAG_W-1:0]   magnitude;
        logic               step_seen;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUMSQ,
        ST_ROOT,
        ST_FINISH
    } ctrl_state_t;

    // absolute value of a two's complement axis, one bit wider
    function automatic logic [ABS_W-1:0] axis_abs(input logic [AXIS_W-1:0] v);
        logic [ABS_W-1:0] ext;
        ext = {v[AXIS_W-1], v};
        return v[AXIS_W-1] ? (ABS_W'(0) - ext) : ext;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/amsc_sumsq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module amsc_sumsq (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [amsc_pkg::AXIS_W-1:0]    accel_x,
    input  wire logic [amsc_pkg::AXIS_W-1:0]    accel_y,
    input  wire logic [amsc_pkg::AXIS_W-1:0]    accel_z,
    output logic                                done,
    output logic [amsc_pkg::SUM_W-1:0]          sum
);
    import amsc_pkg::*;

    logic             busy_reg, busy_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [SUM_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [ABS_W-1:0] operand;

    // pick the axis for the shared multiplier
    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    operand = axis_abs(accel_x);
            2'd1:    operand = axis_abs(accel_y);
            2'd2:    operand = axis_abs(accel_z);
            default: operand = '0;
        endcase
    end

    // one square per cycle, each accumulated in the next cycle from the product register
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        prod_next = {{(SUM_W-ABS_W){1'b0}}, operand} * {{(SUM_W-ABS_W){1'b0}}, operand};
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 2'd0)
            begin
                acc_next = acc_reg + prod_reg;
            end
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/amsc_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module amsc_isqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [amsc_pkg::SUM_W-1:0]  radicand,
    output logic                             done,
    output logic [amsc_pkg::MAG_W-1:0]       root
);
    import amsc_pkg::*;

    localparam int REM_W  = MAG_W + 1;
    localparam int TRY_W  = REM_W + 2;
    localparam int STEP_W = $clog2(MAG_W);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [SUM_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  root_reg, root_next;
    logic [TRY_W-1:0]  shifted;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  diff;
    logic              take;

    // one restoring step: bring down two bits, try 4*root+1
    assign shifted = {rem_reg, rad_reg[SUM_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign diff    = shifted - trial;
    assign take    = (shifted >= trial);

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[SUM_W-3:0], 2'b00};
            rem_next  = take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_next = {root_reg[MAG_W-2:0], take};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hdl/accel_magnitude_step_counter.sv =====
// Pedometer on raw accelerometer samples. Each input transfer carries a
// function code: an acceleration sample (three signed 16-bit axes), a
// pause button level, or a clear of the step count; code 3 is ignored.
// For a sample the magnitude is the floor square root of x*x + y*y + z*z
// in raw lsb; a step counts when it differs from the previous sample's
// magnitude by more than step_threshold (register at address 0, reset
// 13361) while not paused, and the count saturates at 65535. Every input
// transfer yields exactly one output transfer with the count, the pause
// flag, the latest magnitude and whether this item counted a step. The
// block handles one item at a time and takes no new item until the last
// is through: a sample passes the one shared 17x17 multiplier for the sum
// of squares, then the bit-serial square root and the final update step;
// a button or clear item goes straight to the final update step. The input
// is accepted again while a finished result waits in the output register;
// a held output only delays the final update step.
`timescale 1ns / 1ps
`default_nettype none

module accel_magnitude_step_counter (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire amsc_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output amsc_pkg::out_item_t                 out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [amsc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [amsc_pkg::DATA_W-1:0]    pwdata,
    output logic [amsc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import amsc_pkg::*;

    ctrl_state_t        state_reg, state_next;
    in_item_t           item_reg;
    logic [MAG_W-1:0]   thr_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               pause_reg, pause_next;
    logic               held_reg, held_next;
    logic [MAG_W-1:0]   last_mag_reg, last_mag_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic               in_xfer;
    logic               out_free;
    logic               sq_start, sq_done;
    logic [SUM_W-1:0]   sq_sum;
    logic               rt_start, rt_done;
    logic [MAG_W-1:0]   rt_root;
    logic               finish;
    logic               reg_sel;
    logic [MAG_W-1:0]   mag_diff;
    logic               seen;

    // configuration port
    assign pready  = 1'b1;
    assign reg_sel = (paddr[ADDR_W-1:2] == REG_THRESHOLD);
    assign prdata  = reg_sel ? {{(DATA_W-MAG_W){1'b0}}, thr_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            thr_reg <= pwdata[MAG_W-1:0];
        end
    end

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // shared arithmetic units
    amsc_sumsq u_sumsq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .accel_x (item_reg.accel_x),
        .accel_y (item_reg.accel_y),
        .accel_z (item_reg.accel_z),
        .done    (sq_done),
        .sum     (sq_sum)
    );

    amsc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .radicand (sq_sum),
        .done     (rt_done),
        .root     (rt_root)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sq_start   = 1'b0;
        rt_start   = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.func == FUNC_SAMPLE)
                    begin
                        // sum of squares starts at the edge that captures the sample
                        sq_start   = 1'b1;
                        state_next = ST_SUMSQ;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SUMSQ:
            begin
                if (sq_done)
                begin
                    rt_start   = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (rt_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // step detection on the new magnitude
    assign mag_diff = (rt_root > last_mag_reg) ? (rt_root - last_mag_reg)
                                               : (last_mag_reg - rt_root);

    // state update and result
    always_comb
    begin
        count_next    = count_reg;
        pause_next    = pause_reg;
        held_next     = held_reg;
        last_mag_next = last_mag_reg;
        seen          = 1'b0;
        unique case (item_reg.func)
            FUNC_SAMPLE:
            begin
                if ((mag_diff > thr_reg) && !pause_reg)
                begin
                    seen = 1'b1;
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                last_mag_next = rt_root;
            end
            FUNC_BUTTON:
            begin
                if (item_reg.button_level)
                begin
                    if (!held_reg)
                    begin
                        held_next  = 1'b1;
                        pause_next = !pause_reg;
                    end
                end
                else
                begin
                    held_next = 1'b0;
                end
            end
            FUNC_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        out_data_next.step_count = count_next;
        out_data_next.is_paused  = pause_next;
        out_data_next.magnitude  = last_mag_next;
        out_data_next.step_seen  = seen;
        out_valid_next = out_valid_reg && out_stall;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control and step state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pause_reg     <= 1'b0;
            held_reg      <= 1'b0;
            last_mag_reg  <= LAST_MAG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                count_reg    <= count_next;
                pause_reg    <= pause_next;
                held_reg     <= held_next;
                last_mag_reg <= last_mag_next;
            end
        end
    end

    // captured item and output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= in_data;
        end
        if (finish)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // square root only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        rt_done |-> (state_reg == ST_ROOT))
        else $error("square root done outside root phase");

    // sum of squares only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == ST_SUMSQ))
        else $error("sum of squares done outside its phase");

    // a counted step never comes from a paused block
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.step_seen) |-> !out_data_reg.is_paused)
        else $error("step reported while paused");

    // the count saturates instead of wrapping
    assert property (@(posedge clk) disable iff (!rst_n)
        (finish && count_reg == COUNT_MAX && item_reg.func != FUNC_CLEAR)
        |=> (count_reg == COUNT_MAX))
        else $error("step count wrapped");

endmodule

`default_nettype wire
